// ===== hw/rtl/adjacency_bitmap_rank_engine_top_defines.svh =====
// Assertion macros shared by the adjacency bitmap rank engine RTL.
`ifndef ADJACENCY_BITMAP_RANK_ENGINE_TOP_DEFINES_SVH
`define ADJACENCY_BITMAP_RANK_ENGINE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define ABRE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("abre: same-cycle check failed");

// Check that cons holds in the cycle after ante, outside reset.
`define ABRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("abre: next-cycle check failed");

`endif

// ===== hw/rtl/abre_pkg.sv =====
// Shared types, codes and helpers of the adjacency bitmap rank engine.
`default_nettype none
package abre_pkg;

    localparam int ROW_W       = 64;  // neighbor bits per row
    localparam int VID_W       = 6;   // vertex id width
    localparam int CNT_W       = 7;   // vertex count width
    localparam int BYTE_GROUPS = 8;   // byte groups of a row for the rank count
    localparam int TDATA_W     = 16;

    typedef enum logic [2:0] {
        CMD_SET   = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_TEST  = 3'd2,
        CMD_RANK  = 3'd3,
        CMD_LIST  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NONE  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/abre_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module abre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/adjacency_bitmap_rank_engine_top.sv =====
// Top level of the adjacency bitmap rank engine.
//
// Keeps a directed graph as one 64-bit neighbor row per vertex in a single
// synchronous RAM; a row valid bit per vertex, cleared at reset, makes every
// row read as empty until first written, so no clearing pass is needed and
// the block takes commands right after reset. Commands are handled one at a
// time. Set, clear and test accept the command, then use the registered row
// read; set and clear write back the modified row. Rank goes on from the row
// read to per-byte bit counts, then their sum. An out-of-range command skips
// the row read. List emits one neighbor per cycle while the output register
// is free or being taken, so a stalled sink holds the scan.
// A finished result sits in the output register, so the block returns to
// accepting while it waits to be taken. Codes 5 to 7 are dropped silently.
`default_nettype none
`include "adjacency_bitmap_rank_engine_top_defines.svh"
module adjacency_bitmap_rank_engine_top
    import abre_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Command stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // [2:0] command, [8:3] src_vertex, [14:9] dst_vertex, [15] zero
    input  wire logic [TDATA_W-1:0] s_tdata,
    // Result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [1:0] status, [2] edge_present, [8:3] rank, [14:9] neighbor_id, [15] zero
    output logic [TDATA_W-1:0]      m_tdata,
    output logic                    m_tlast,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam logic [CNT_W-1:0] MAXV_C = CNT_W'(MAX_VERTICES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COUNT,
        ST_LIST,
        ST_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [CNT_W-1:0] vertex_count_reg;
    logic [CNT_W-1:0] n_eff;
    logic             cfg_wr;

    // Latched command
    logic [2:0]       cmd_reg;
    logic [VID_W-1:0] src_reg;
    logic [VID_W-1:0] dst_reg;

    // Row storage
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    mem_we;
    logic [ROW_W-1:0]        mem_wdata;
    logic [ROW_W-1:0]        mem_rdata;
    logic [ADDR_W-1:0]       src_idx;

    // Work registers
    logic [3:0]       cnt_reg [BYTE_GROUPS];
    logic [ROW_W-1:0] live_reg;
    logic [VID_W-1:0] k_reg;

    // Pending result
    logic [1:0]       res_status_reg;
    logic             res_ep_reg;
    logic [VID_W-1:0] res_rank_reg;

    // Output register
    logic             m_tvalid_reg;
    logic [1:0]       m_status_reg;
    logic             m_ep_reg;
    logic [VID_W-1:0] m_rank_reg;
    logic [VID_W-1:0] m_vid_reg;
    logic             m_tlast_reg;

    // Input decode
    logic             s_accept;
    logic [2:0]       s_cmd;
    logic [VID_W-1:0] s_src;
    logic [VID_W-1:0] s_dst;
    logic             s_known;
    logic             s_oor;

    // Row-read stage logic
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] bit_mask;
    logic [ROW_W-1:0] below;
    logic [ROW_W-1:0] live_rd;
    logic             present;
    logic [1:0]       rd_status;
    logic             rd_ep;
    logic             go_count;
    logic             go_list;

    // Count and list logic
    logic [CNT_W-1:0] rank_sum;
    logic [VID_W-1:0] first_idx;
    logic [ROW_W-1:0] live_next;
    logic             out_free;
    logic             m_load;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT[0]);
    assign prdata   = (paddr[2] == REG_VERTEX_COUNT[0]) ? {25'd0, vertex_count_reg} : '0;
    // Clamp the count to the row storage depth
    assign n_eff    = (vertex_count_reg > MAXV_C) ? MAXV_C : vertex_count_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_cmd    = s_tdata[2:0];
    assign s_src    = s_tdata[8:3];
    assign s_dst    = s_tdata[14:9];
    assign s_known  = (s_cmd <= CMD_LIST);
    assign s_oor    = ({1'b0, s_src} >= n_eff) ||
                      ((s_cmd != CMD_LIST) && ({1'b0, s_dst} >= n_eff));

    assign out_free = !m_tvalid_reg || m_tready;
    assign src_idx  = src_reg[ADDR_W-1:0];

    // Row read: a never-written row reads as empty
    always_comb begin
        row_rd   = row_valid_reg[src_idx] ? mem_rdata : '0;
        bit_mask = ROW_W'(1) << dst_reg;
        below    = row_rd & (bit_mask - ROW_W'(1));
        present  = row_rd[dst_reg];
        for (int i = 0; i < ROW_W; i++) begin
            live_rd[i] = row_rd[i] && (CNT_W'(i) < n_eff);
        end
        rd_status = STAT_OK;
        rd_ep     = 1'b0;
        go_count  = 1'b0;
        go_list   = 1'b0;
        case (cmd_reg)
            CMD_SET: begin
                rd_ep = 1'b1;
            end
            CMD_CLEAR: begin
                rd_ep = 1'b0;
            end
            CMD_RANK: begin
                go_count  = present;
                rd_status = present ? STAT_OK : STAT_NONE;
                rd_ep     = present;
            end
            CMD_LIST: begin
                go_list   = (live_rd != '0);
                rd_status = STAT_NONE;
            end
            default: begin
                rd_status = present ? STAT_OK : STAT_NONE;
                rd_ep     = present;
            end
        endcase
    end

    assign mem_we    = (state_reg == ST_READ) &&
                       ((cmd_reg == CMD_SET) || (cmd_reg == CMD_CLEAR));
    assign mem_wdata = (cmd_reg == CMD_SET) ? (row_rd | bit_mask) : (row_rd & ~bit_mask);

    // A new result enters the output register this cycle
    assign m_load = out_free &&
                    (((state_reg == ST_READ) && !go_count && !go_list) ||
                     (state_reg == ST_LIST) || (state_reg == ST_OUT));

    always_comb begin
        rank_sum = '0;
        for (int g = 0; g < BYTE_GROUPS; g++) begin
            rank_sum = rank_sum + CNT_W'(cnt_reg[g]);
        end
    end

    // Lowest remaining neighbor of the list scan
    always_comb begin
        first_idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (live_reg[i]) begin
                first_idx = VID_W'(i);
            end
        end
        live_next = live_reg & (live_reg - ROW_W'(1));
    end

    abre_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_VERTICES)
    ) u_rows (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(src_idx),
        .wdata(mem_wdata),
        .raddr(s_src[ADDR_W-1:0]),
        .rdata(mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            row_valid_reg    <= '0;
            vertex_count_reg <= '0;
        end else begin
            if (cfg_wr) begin
                vertex_count_reg <= pwdata[CNT_W-1:0];
            end
            // Retire the result once the sink takes it, unless a new one loads
            if (m_tvalid_reg && m_tready && !m_load) begin
                m_tvalid_reg <= 1'b0;
            end
            if (mem_we) begin
                row_valid_reg[src_idx] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && s_known) begin
                        cmd_reg <= s_cmd;
                        src_reg <= s_src;
                        dst_reg <= s_dst;
                        if (s_oor) begin
                            res_status_reg <= STAT_RANGE;
                            res_ep_reg     <= 1'b0;
                            res_rank_reg   <= '0;
                            state_reg      <= ST_OUT;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    for (int g = 0; g < BYTE_GROUPS; g++) begin
                        cnt_reg[g] <= popcount8(below[g*8 +: 8]);
                    end
                    live_reg <= live_rd;
                    k_reg    <= '0;
                    if (go_count) begin
                        state_reg <= ST_COUNT;
                    end else if (go_list) begin
                        state_reg <= ST_LIST;
                    end else if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= rd_status;
                        m_ep_reg     <= rd_ep;
                        m_rank_reg   <= '0;
                        m_vid_reg    <= '0;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end else begin
                        res_status_reg <= rd_status;
                        res_ep_reg     <= rd_ep;
                        res_rank_reg   <= '0;
                        state_reg      <= ST_OUT;
                    end
                end
                ST_COUNT: begin
                    res_status_reg <= STAT_OK;
                    res_ep_reg     <= 1'b1;
                    res_rank_reg   <= rank_sum[VID_W-1:0];
                    state_reg      <= ST_OUT;
                end
                ST_LIST: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= STAT_OK;
                        m_ep_reg     <= 1'b1;
                        m_rank_reg   <= k_reg;
                        m_vid_reg    <= first_idx;
                        m_tlast_reg  <= (live_next == '0);
                        live_reg     <= live_next;
                        k_reg        <= k_reg + VID_W'(1);
                        if (live_next == '0) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_ep_reg     <= res_ep_reg;
                        m_rank_reg   <= res_rank_reg;
                        m_vid_reg    <= '0;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {1'b0, m_vid_reg, m_rank_reg, m_ep_reg, m_status_reg};

    // Row writes only come out of the row-read stage
    `ABRE_ASSERT_SAME(a_write_in_read, mem_we, state_reg == ST_READ)
    // The list scan never runs on an empty row
    `ABRE_ASSERT_SAME(a_list_nonempty, state_reg == ST_LIST, live_reg != '0)
    // Error and empty results are single, so they close the command
    `ABRE_ASSERT_SAME(a_err_is_last, m_tvalid_reg && (m_status_reg != STAT_OK), m_tlast_reg)
    // Unknown codes are dropped without leaving idle
    `ABRE_ASSERT_NEXT(a_drop_unknown, s_accept && !s_known, state_reg == ST_IDLE)

endmodule
`default_nettype wire
